>>> rtl/assert_macros.svh
// Assertion macros shared by the load estimator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or sequence property on every rising edge outside reset.
`define ICBP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ICBP_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/icbp_pkg.sv
// Types and constants of the idle-count busy-percent estimator.
package icbp_pkg;

  localparam int MAX_CORES = 2;
  localparam int CORE_W    = 1;
  localparam int COUNT_W   = 32;
  localparam int TIME_W    = 63;
  localparam int RATE_W    = 52;
  localparam int BUSY_W    = 7;
  localparam int US_W      = 20;
  localparam int IDLE_W    = RATE_W + BUSY_W;
  localparam int REM_W     = TIME_W;
  localparam int ACC_W     = TIME_W + 1;
  localparam int DCNT_W    = 6;

  localparam logic [US_W-1:0]   US_PER_SECOND = 20'd1000000;
  localparam logic [BUSY_W-1:0] FULL_PERCENT  = 7'd100;

  // Quotient bits produced by each division.
  localparam logic [DCNT_W-1:0] RATE_STEPS = 6'd52;
  localparam logic [DCNT_W-1:0] IDLE_STEPS = 6'd7;

  typedef struct packed {
    logic              capture;
    logic              eval;
    logic              mul_rate;
    logic              mul_idle;
    logic              div_step;
    logic              write_busy;
    logic              commit;
    logic [CORE_W-1:0] core;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fresh;
    logic div_last;
  } ctrl_status_t;

endpackage

>>> rtl/icbp_sample_if.sv
// Sample channel: idle counters of each core and a microsecond timestamp.
interface icbp_sample_if;
  logic                             valid;
  logic                             ready;
  logic [icbp_pkg::COUNT_W-1:0]     idle_count_core0;
  logic [icbp_pkg::COUNT_W-1:0]     idle_count_core1;
  logic [icbp_pkg::TIME_W-1:0]      time_us;

  modport source (output valid, idle_count_core0, idle_count_core1, time_us, input ready);
  modport sink (input valid, idle_count_core0, idle_count_core1, time_us, output ready);
endinterface

>>> rtl/icbp_result_if.sv
// Result channel: busy percent of each core with freshness and validity flags.
interface icbp_result_if;
  logic                          valid;
  logic                          ready;
  logic                          fresh_result;
  logic [icbp_pkg::BUSY_W-1:0]   busy_core0;
  logic [icbp_pkg::BUSY_W-1:0]   busy_core1;
  logic                          published_valid;

  modport source (output valid, fresh_result, busy_core0, busy_core1, published_valid,
                  input ready);
  modport sink (input valid, fresh_result, busy_core0, busy_core1, published_valid,
                output ready);
endinterface

>>> rtl/icbp_ctrl.sv
// Sequencer of the estimator: steps each core through multiply, divide and publish.
`include "assert_macros.svh"

module icbp_ctrl #(
  parameter int CORE_COUNT = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  icbp_pkg::ctrl_status_t  status,
  output icbp_pkg::ctrl_cmd_t     cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EVAL     = 3'd1;
  localparam logic [2:0] S_MUL_RATE = 3'd2;
  localparam logic [2:0] S_DIV_RATE = 3'd3;
  localparam logic [2:0] S_MUL_IDLE = 3'd4;
  localparam logic [2:0] S_DIV_IDLE = 3'd5;
  localparam logic [2:0] S_WRITE    = 3'd6;
  localparam logic [2:0] S_COMMIT   = 3'd7;

  localparam logic [icbp_pkg::CORE_W-1:0] LAST_CORE = icbp_pkg::CORE_W'(CORE_COUNT - 1);

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [icbp_pkg::CORE_W-1:0] core;
  logic [icbp_pkg::CORE_W-1:0] core_next;
  logic                        result_valid;
  logic                        result_valid_next;
  logic                        accept;
  logic                        stall;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = result_valid;
  assign stall     = result_valid && !out_ready;

  always_comb begin
    cmd        = '0;
    cmd.core   = core;
    state_next = state;
    core_next  = core;
    case (state)
      S_IDLE: begin
        cmd.capture = accept;
        if (accept) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        core_next = '0;
        if (status.fresh) begin
          state_next = S_MUL_RATE;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_MUL_RATE: begin
        cmd.mul_rate = 1'b1;
        state_next   = S_DIV_RATE;
      end
      S_DIV_RATE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_MUL_IDLE;
        end
      end
      S_MUL_IDLE: begin
        cmd.mul_idle = 1'b1;
        state_next   = S_DIV_IDLE;
      end
      S_DIV_IDLE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_busy = 1'b1;
        if (core == LAST_CORE) begin
          state_next = S_COMMIT;
        end else begin
          core_next  = core + 1'b1;
          state_next = S_MUL_RATE;
        end
      end
      S_COMMIT: begin
        if (!stall) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      result_valid_next = 1'b1;
    end else if (out_ready) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      core         <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      core         <= core_next;
      result_valid <= result_valid_next;
    end
  end

  `ICBP_ASSERT(a_accept_to_eval, clk, rst, accept |=> state == S_EVAL, "accept did not start eval")
  `ICBP_ASSERT(a_stale_commits, clk, rst, (state == S_EVAL && !status.fresh) |=> state == S_COMMIT, "stale sample did not go to commit")
  `ICBP_ASSERT_NEVER(a_commit_on_stall, clk, rst, cmd.commit && stall, "commit over a pending result")

endmodule

>>> rtl/icbp_dp.sv
// Datapath of the estimator: sample state, multipliers, shared serial divider, results.
`include "assert_macros.svh"

module icbp_dp #(
  parameter int CORE_COUNT = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  icbp_pkg::ctrl_cmd_t                 cmd,
  output icbp_pkg::ctrl_status_t              status,
  input  logic [icbp_pkg::COUNT_W-1:0]        idle_count_core0,
  input  logic [icbp_pkg::COUNT_W-1:0]        idle_count_core1,
  input  logic [icbp_pkg::TIME_W-1:0]         time_us,
  output logic                                fresh_result,
  output logic [icbp_pkg::BUSY_W-1:0]         busy_core0,
  output logic [icbp_pkg::BUSY_W-1:0]         busy_core1,
  output logic                                published_valid
);

  localparam int COUNT_W = icbp_pkg::COUNT_W;
  localparam int TIME_W  = icbp_pkg::TIME_W;
  localparam int RATE_W  = icbp_pkg::RATE_W;
  localparam int BUSY_W  = icbp_pkg::BUSY_W;
  localparam int IDLE_W  = icbp_pkg::IDLE_W;
  localparam int REM_W   = icbp_pkg::REM_W;
  localparam int ACC_W   = icbp_pkg::ACC_W;
  localparam int DCNT_W  = icbp_pkg::DCNT_W;
  localparam int NCORE   = icbp_pkg::MAX_CORES;

  logic [COUNT_W-1:0] cur_count  [NCORE];
  logic [COUNT_W-1:0] prev_count [NCORE];
  logic [RATE_W-1:0]  best       [NCORE];
  logic [BUSY_W-1:0]  pub_busy   [NCORE];
  logic [TIME_W-1:0]  cur_time;
  logic [TIME_W-1:0]  prev_time;
  logic [TIME_W-1:0]  step;
  logic               baseline;
  logic               pub_flag;
  logic               fresh_q;
  logic               best_zero;

  logic [REM_W-1:0]   div_rem;
  logic [ACC_W-1:0]   div_acc;
  logic [REM_W-1:0]   div_den;
  logic [DCNT_W-1:0]  div_cnt;

  logic [COUNT_W-1:0] delta;
  logic [RATE_W-1:0]  rate_prod;
  logic [RATE_W-1:0]  rate;
  logic [RATE_W-1:0]  best_new;
  logic [IDLE_W-1:0]  idle_prod;
  logic [ACC_W-1:0]   trial;
  logic [ACC_W-1:0]   diff;
  logic               ge;
  logic [BUSY_W-1:0]  idle_share;
  logic [BUSY_W-1:0]  busy_val;

  assign delta     = cur_count[cmd.core] - prev_count[cmd.core];
  assign rate_prod = RATE_W'(delta) * RATE_W'(icbp_pkg::US_PER_SECOND);
  assign rate      = div_acc[RATE_W-1:0];
  assign best_new  = (rate > best[cmd.core]) ? rate : best[cmd.core];
  assign idle_prod = IDLE_W'(rate) * IDLE_W'(icbp_pkg::FULL_PERCENT);

  assign trial = {div_rem, div_acc[ACC_W-1]};
  assign ge    = (trial >= {1'b0, div_den});
  assign diff  = trial - {1'b0, div_den};

  assign idle_share = (div_acc[BUSY_W-1:0] > icbp_pkg::FULL_PERCENT) ?
                      icbp_pkg::FULL_PERCENT : div_acc[BUSY_W-1:0];
  assign busy_val = best_zero ? icbp_pkg::FULL_PERCENT : (icbp_pkg::FULL_PERCENT - idle_share);

  assign status.fresh    = baseline && (cur_time > prev_time);
  assign status.div_last = (div_cnt == DCNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_count[0] <= idle_count_core0;
      cur_count[1] <= idle_count_core1;
      cur_time     <= time_us;
    end
    if (cmd.eval) begin
      fresh_q <= status.fresh;
      step    <= cur_time - prev_time;
    end
    if (cmd.mul_rate) begin
      div_rem <= '0;
      div_acc <= {rate_prod, (ACC_W - RATE_W)'(0)};
      div_den <= step;
      div_cnt <= icbp_pkg::RATE_STEPS;
    end else if (cmd.mul_idle) begin
      best_zero <= (best_new == '0);
      div_rem   <= REM_W'(idle_prod[IDLE_W-1:BUSY_W]);
      div_acc   <= {idle_prod[BUSY_W-1:0], (ACC_W - BUSY_W)'(0)};
      div_den   <= REM_W'(best_new);
      div_cnt   <= icbp_pkg::IDLE_STEPS;
    end else if (cmd.div_step) begin
      div_rem <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      div_acc <= {div_acc[ACC_W-2:0], ge};
      div_cnt <= div_cnt - 1'b1;
    end
    if (cmd.commit) begin
      fresh_result    <= fresh_q;
      busy_core0      <= pub_busy[0];
      busy_core1      <= (CORE_COUNT > 1) ? pub_busy[1] : '0;
      published_valid <= pub_flag || fresh_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NCORE; c++) begin
        prev_count[c] <= '0;
        best[c]       <= '0;
        pub_busy[c]   <= '0;
      end
      prev_time <= '0;
      baseline  <= 1'b0;
      pub_flag  <= 1'b0;
    end else begin
      if (cmd.mul_idle) begin
        best[cmd.core] <= best_new;
      end
      if (cmd.write_busy) begin
        pub_busy[cmd.core] <= busy_val;
      end
      if (cmd.commit) begin
        for (int c = 0; c < NCORE; c++) begin
          prev_count[c] <= cur_count[c];
        end
        prev_time <= cur_time;
        baseline  <= 1'b1;
        pub_flag  <= pub_flag || fresh_q;
      end
    end
  end

  `ICBP_ASSERT_NEVER(a_div_overrun, clk, rst, cmd.div_step && (div_cnt == '0), "divider stepped past its last bit")
  `ICBP_ASSERT(a_busy_range, clk, rst, cmd.write_busy |=> pub_busy[$past(cmd.core)] <= icbp_pkg::FULL_PERCENT, "busy percent above full scale")

endmodule

>>> rtl/idle_count_busy_percent.sv
// Top level of the per-core busy percent estimator.
// Usage:
//   sample (sink): one transaction per load sample, carrying each core's
//   free-running idle counter and a microsecond timestamp.
//   result (source): exactly one transaction per sample, with the busy
//   percent of each core, fresh_result and published_valid.
// The first sample after reset only stores a baseline; a sample whose
// timestamp does not advance gives no fresh result. Both repeat the last
// published values. Otherwise each core's idle rate goes through one
// 52-step and one 7-step pass of a shared restoring divider.
// A sample with no fresh result goes from eval straight to commit;
// otherwise each core passes through rate multiply, rate divide, idle
// multiply, idle divide and write. One sample is in work at a time; the
// next is accepted the cycle after the result register is loaded.
// A stalled receiver holds the result register; a new sample may still be
// accepted and worked up to its final load, which waits for the transfer.
// Reset (rst, synchronous) clears the baseline, peak rates and published
// values and drops any pending result.
module idle_count_busy_percent #(
  parameter int CORE_COUNT = 2
) (
  input  logic             clk,
  input  logic             rst,
  icbp_sample_if.sink      sample,
  icbp_result_if.source    result
);

  icbp_pkg::ctrl_cmd_t    cmd;
  icbp_pkg::ctrl_status_t status;

  icbp_ctrl #(
    .CORE_COUNT (CORE_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  icbp_dp #(
    .CORE_COUNT (CORE_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .idle_count_core0 (sample.idle_count_core0),
    .idle_count_core1 (sample.idle_count_core1),
    .time_us          (sample.time_us),
    .fresh_result     (result.fresh_result),
    .busy_core0       (result.busy_core0),
    .busy_core1       (result.busy_core1),
    .published_valid  (result.published_valid)
  );

endmodule

>>> tb/sv/busy_percent_checker.sv
// Checker that predicts busy percent reports from accepted samples and compares results.
`timescale 1ns / 1ps

module busy_percent_checker
  import icbp_pkg::*;
#(
  parameter int CORES = 2
) (
  input  logic   clk,
  input  logic   rst,
  icbp_sample_if sample,
  icbp_result_if result,
  output int     mismatches,
  output int     pending
);

  typedef struct packed {
    logic              fresh;
    logic [BUSY_W-1:0] busy0;
    logic [BUSY_W-1:0] busy1;
    logic              published;
  } busy_report_t;

  logic [COUNT_W-1:0] last_count [MAX_CORES];
  logic [63:0]        last_stamp;
  logic [RATE_W-1:0]  peak_rate [MAX_CORES];
  logic               have_baseline;
  logic [BUSY_W-1:0]  shown_busy [MAX_CORES];
  logic               shown_valid;

  busy_report_t awaited_reports [$];
  int           errors_seen;

  assign mismatches = errors_seen;

  function automatic busy_report_t predict_busy_report(input logic [COUNT_W-1:0] cnt0,
                                                       input logic [COUNT_W-1:0] cnt1,
                                                       input logic [TIME_W-1:0]  stamp);
    logic [COUNT_W-1:0] cnt [MAX_CORES];
    logic [COUNT_W-1:0] delta;
    logic [63:0]        now64;
    logic [63:0]        span;
    logic [63:0]        rate;
    logic [63:0]        idle;
    busy_report_t       rep;
    cnt[0] = cnt0;
    cnt[1] = cnt1;
    now64 = {1'b0, stamp};
    rep.fresh = 1'b0;
    if (have_baseline && now64 > last_stamp) begin
      span = now64 - last_stamp;
      for (int c = 0; c < CORES; c++) begin
        delta = cnt[c] - last_count[c];
        rate = (64'(delta) * 64'(US_PER_SECOND)) / span;
        if (rate > 64'(peak_rate[c])) begin
          peak_rate[c] = rate[RATE_W-1:0];
        end
        if (peak_rate[c] == '0) begin
          shown_busy[c] = FULL_PERCENT;
        end else begin
          idle = (rate * 64'(FULL_PERCENT)) / 64'(peak_rate[c]);
          if (idle > 64'(FULL_PERCENT)) begin
            idle = 64'(FULL_PERCENT);
          end
          shown_busy[c] = FULL_PERCENT - idle[BUSY_W-1:0];
        end
      end
      shown_valid = 1'b1;
      rep.fresh = 1'b1;
    end
    for (int c = 0; c < CORES; c++) begin
      last_count[c] = cnt[c];
    end
    last_stamp = now64;
    have_baseline = 1'b1;
    rep.busy0 = shown_busy[0];
    rep.busy1 = (CORES > 1) ? shown_busy[1] : '0;
    rep.published = shown_valid;
    return rep;
  endfunction

  task automatic note_mismatch(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    errors_seen++;
    if (errors_seen <= 10) begin
      $display("busy report mismatch on %s: expected %0d, got %0d (t=%0t)",
               field, want, got, $realtime);
    end
  endtask

  always @(posedge clk) begin : track
    busy_report_t want;
    if (rst) begin
      for (int c = 0; c < MAX_CORES; c++) begin
        last_count[c] = '0;
        peak_rate[c] = '0;
        shown_busy[c] = '0;
      end
      last_stamp = '0;
      have_baseline = 1'b0;
      shown_valid = 1'b0;
      awaited_reports.delete();
      errors_seen = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (awaited_reports.size() == 0) begin
          errors_seen++;
          if (errors_seen <= 10) begin
            $display("busy report with no prediction waiting: fresh %0b busy %0d/%0d valid %0b",
                     result.fresh_result, result.busy_core0, result.busy_core1,
                     result.published_valid);
          end
        end else begin
          want = awaited_reports.pop_front();
          if (result.fresh_result !== want.fresh) begin
            note_mismatch("fresh_result", 8'(want.fresh), 8'(result.fresh_result));
          end
          if (result.busy_core0 !== want.busy0) begin
            note_mismatch("busy_core0", 8'(want.busy0), 8'(result.busy_core0));
          end
          if (result.busy_core1 !== want.busy1) begin
            note_mismatch("busy_core1", 8'(want.busy1), 8'(result.busy_core1));
          end
          if (result.published_valid !== want.published) begin
            note_mismatch("published_valid", 8'(want.published), 8'(result.published_valid));
          end
        end
      end
      if (sample.valid && sample.ready) begin
        awaited_reports.push_back(predict_busy_report(sample.idle_count_core0,
                                                      sample.idle_count_core1,
                                                      sample.time_us));
      end
    end
    pending <= awaited_reports.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Top of the busy percent estimator testbench: clock, reset, sample stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import icbp_pkg::*;

  localparam int CORE_COUNT     = 2;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 335;

  typedef enum {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_mode_t;

  logic       clk;
  logic       rst;
  int         mismatches;
  int         pending;
  int         quiet_cycles;
  flow_mode_t flow;

  logic [COUNT_W-1:0] run_count [MAX_CORES];
  logic [TIME_W-1:0]  run_stamp;
  int unsigned        full_rate [MAX_CORES];

  icbp_sample_if sample();
  icbp_result_if result();

  idle_count_busy_percent #(.CORE_COUNT(CORE_COUNT)) dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .result (result)
  );

  busy_percent_checker #(.CORES(CORE_COUNT)) load_check (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .result     (result),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin : receiver
    int stall_pct;
    stall_pct = (flow == FLOW_RECEIVER_STALL) ? 88 : (flow == FLOW_BOTH) ? 31 : 0;
    result.ready <= !($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (sample.valid && sample.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_sample(input logic [COUNT_W-1:0] c0, input logic [COUNT_W-1:0] c1,
                             input logic [TIME_W-1:0] stamp);
    int gap_pct;
    gap_pct = (flow == FLOW_SENDER_IDLE) ? 88 : (flow == FLOW_BOTH) ? 31 : 0;
    while ($urandom_range(99) < gap_pct) begin
      sample.valid <= 1'b0;
      @(posedge clk);
    end
    sample.valid            <= 1'b1;
    sample.idle_count_core0 <= c0;
    sample.idle_count_core1 <= c1;
    sample.time_us          <= stamp;
    run_count[0] = c0;
    run_count[1] = c1;
    run_stamp    = stamp;
    do @(posedge clk); while (!sample.ready);
  endtask

  // Hold the sender until every predicted report has been received.
  task automatic wait_for_results();
    sample.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_random();
    logic [TIME_W-1:0]  span;
    logic [63:0]        scaled;
    logic [COUNT_W-1:0] next_count [MAX_CORES];
    logic [TIME_W-1:0]  next_stamp;
    int unsigned        pick;
    int unsigned        span_pick;
    pick = $urandom_range(99);
    if (pick < 85) begin
      span_pick = $urandom_range(9);
      if (span_pick < 6) begin
        span = TIME_W'($urandom_range(1, 5000));
      end else if (span_pick < 8) begin
        span = TIME_W'($urandom_range(1, 8));
      end else if (span_pick < 9) begin
        span = TIME_W'($urandom_range(5000, 2000000));
      end else begin
        span = TIME_W'({$urandom(), $urandom()}) >> $urandom_range(1, 40);
        if (span == '0) begin
          span = TIME_W'(1);
        end
      end
      next_stamp = run_stamp + span;
      for (int c = 0; c < MAX_CORES; c++) begin
        if ($urandom_range(19) == 0) begin
          next_count[c] = run_count[c] + $urandom();
        end else begin
          scaled = 64'(span) * 64'(full_rate[c]) * 64'($urandom_range(0, 100)) / 64'd100;
          next_count[c] = run_count[c] + scaled[COUNT_W-1:0];
        end
      end
    end else if (pick < 93) begin
      next_stamp = run_stamp - TIME_W'($urandom_range(0, 3));
      for (int c = 0; c < MAX_CORES; c++) begin
        next_count[c] = run_count[c] + COUNT_W'($urandom_range(0, 5000));
      end
    end else begin
      next_stamp = TIME_W'({$urandom(), $urandom()});
      for (int c = 0; c < MAX_CORES; c++) begin
        next_count[c] = $urandom();
      end
    end
    send_sample(next_count[0], next_count[1], next_stamp);
  endtask

  initial begin
    rst                     = 1'b1;
    flow                    = FLOW_FREE;
    sample.valid            = 1'b0;
    sample.idle_count_core0 = '0;
    sample.idle_count_core1 = '0;
    sample.time_us          = '0;
    result.ready            = 1'b0;
    quiet_cycles            = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(32'd0, 32'd0, 63'd0);
    send_sample(32'd10, 32'd20, 63'd0);
    send_sample(32'd510, 32'd20, 63'd1000);
    send_sample(32'd760, 32'd1020, 63'd2000);
    send_sample(32'd760, 32'd1020, 63'd3000);
    send_sample(32'hFFFF_FF00, 32'hFFFF_FFFF, 63'd3000);
    send_sample(32'h0000_00F4, 32'h0000_01F3, 63'd4000);
    send_sample(32'h0000_00F3, 32'h0000_01F3, 63'd4001);
    send_sample(32'h0000_00F3, 32'h0000_01F3, 63'h7FFF_FFFF_FFFF_FFFF);
    send_sample(32'd0, 32'd0, 63'd0);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 63'd1);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 63'h4000_0000_0000_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFE);
    wait_for_results();

    for (int m = 0; m < 4; m++) begin
      flow = flow_mode_t'(m);
      for (int c = 0; c < MAX_CORES; c++) begin
        full_rate[c] = $urandom_range(1, 1000);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_random();
      end
      wait_for_results();
    end

    repeat (140) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/icbp_pkg.sv
rtl/icbp_sample_if.sv
rtl/icbp_result_if.sv
rtl/icbp_ctrl.sv
rtl/icbp_dp.sv
rtl/idle_count_busy_percent.sv
tb/sv/busy_percent_checker.sv
tb/sv/tb_top.sv
